@@ rtl/hmmfp_pkg.sv @@
// hmmfp_pkg: shared widths, opcodes and pipeline tag type for the HMM forward
// state predictor. No dependencies; imported by every rtl module.
`default_nettype none

package hmmfp_pkg;

  localparam int DEF_MAX_STATES  = 16;
  localparam int DEF_MAX_SYMBOLS = 64;

  localparam int OPC_W   = 2;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int OBS_W   = 6;
  localparam int NS_W    = 5;
  localparam int PRED_W  = 4;
  localparam int PROB_W  = 17;
  localparam int ALPHA_W = 32;

  localparam logic [PROB_W-1:0] PROB_ONE     = 17'h10000;
  localparam logic [NS_W-1:0]   NS_RESET_VAL = 5'd16;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD_INIT  = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_LOAD_EMIS  = 2'd2,
    OP_OBSERVE    = 2'd3
  } opcode_t;

  // tag that travels with each multiply through the shared unit
  typedef struct packed {
    logic valid;
    logic is_raw;   // product is a finished raw alpha, not a partial sum term
    logic first_i;  // first term of a sum: restart the accumulator
  } mac_tag_t;

endpackage

`default_nettype wire

@@ rtl/hmmfp_tables.sv @@
// hmmfp_tables: initial, transition and emission probability memories with
// load decode, clamping and registered reads. Depends on hmmfp_pkg.
`default_nettype none

module hmmfp_tables
  import hmmfp_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  localparam int SI_W = $clog2(MAX_STATES),
  localparam int TR_W = $clog2(MAX_STATES * MAX_STATES),
  localparam int EM_W = $clog2(MAX_STATES * MAX_SYMBOLS)
) (
  input  wire logic              clk,
  input  wire logic              load_en,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [ROW_W-1:0]  row_index,
  input  wire logic [COL_W-1:0]  col_index,
  input  wire logic [PROB_W-1:0] prob_value,
  input  wire logic [SI_W-1:0]   init_raddr,
  input  wire logic [TR_W-1:0]   trans_raddr,
  input  wire logic [EM_W-1:0]   emis_raddr,
  output logic      [PROB_W-1:0] init_q,
  output logic      [PROB_W-1:0] trans_q,
  output logic      [PROB_W-1:0] emis_q
);

  logic [PROB_W-1:0] init_mem  [MAX_STATES];
  logic [PROB_W-1:0] trans_mem [MAX_STATES * MAX_STATES];
  logic [PROB_W-1:0] emis_mem  [MAX_STATES * MAX_SYMBOLS];

  logic [31:0]       row32, col32, tr_lin, em_lin;
  logic [PROB_W-1:0] val_c;
  logic              row_ok, trans_ok, emis_ok;

  always_comb begin
    row32    = 32'(row_index);
    col32    = 32'(col_index);
    val_c    = (prob_value > PROB_ONE) ? PROB_ONE : prob_value;
    row_ok   = row32 < 32'(MAX_STATES);
    trans_ok = row_ok && (col32 < 32'(MAX_STATES));
    emis_ok  = row_ok && (col32 < 32'(MAX_SYMBOLS));
    tr_lin   = row32 * 32'(MAX_STATES) + col32;
    em_lin   = row32 * 32'(MAX_SYMBOLS) + col32;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      unique case (opcode_t'(opcode))
        OP_LOAD_INIT: begin
          if (row_ok) init_mem[row32[SI_W-1:0]] <= val_c;
        end
        OP_LOAD_TRANS: begin
          if (trans_ok) trans_mem[tr_lin[TR_W-1:0]] <= val_c;
        end
        OP_LOAD_EMIS: begin
          if (emis_ok) emis_mem[em_lin[EM_W-1:0]] <= val_c;
        end
        default: begin
        end
      endcase
    end
    init_q  <= init_mem[init_raddr];
    trans_q <= trans_mem[trans_raddr];
    emis_q  <= emis_mem[emis_raddr];
  end

endmodule

`default_nettype wire

@@ rtl/hmmfp_mac.sv @@
// hmmfp_mac: the shared multiplier with registered product and the sum
// accumulator. Depends on hmmfp_pkg (mac_tag_t, PROB_W).
`default_nettype none

module hmmfp_mac
  import hmmfp_pkg::*;
#(
  parameter int SUM_W = 52,
  localparam int A_W    = SUM_W - (PROB_W - 1),
  localparam int PROD_W = A_W + PROB_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mac_tag_t          tag_in,
  input  wire logic [A_W-1:0]    a,
  input  wire logic [PROB_W-1:0] b,
  output mac_tag_t               tag_out,
  output logic      [SUM_W-1:0]  prod,
  output logic      [SUM_W-1:0]  acc
);

  logic [PROD_W-1:0] full;

  assign full = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
    // every product in use is below 2**SUM_W
    prod <= full[SUM_W-1:0];
    if (tag_out.valid && !tag_out.is_raw) begin
      acc <= tag_out.first_i ? prod : acc + prod;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hmmfp_norm.sv @@
// hmmfp_norm: iterative top-set-bit search over the largest raw value, one
// binary step per cycle, and the shifter that scales raw values to 32 bits.
// Depends on hmmfp_pkg (ALPHA_W).
`default_nettype none

module hmmfp_norm
  import hmmfp_pkg::*;
#(
  parameter int SUM_W = 52,
  localparam int BIT_W = $clog2(SUM_W),
  localparam int K_W   = (BIT_W > 1) ? $clog2(BIT_W) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   m,
  input  wire logic [SUM_W-1:0]   raw_in,
  output logic                    busy,
  output logic      [ALPHA_W-1:0] alpha_out
);

  localparam logic [BIT_W-1:0] TOP_POS = BIT_W'(ALPHA_W - 1);

  logic [BIT_W-1:0] bitpos;
  logic [K_W-1:0]   k;
  logic [BIT_W:0]   trial;
  logic             shr;
  logic [BIT_W-1:0] amt;
  logic [SUM_W-1:0] shifted;

  assign trial = {1'b0, bitpos} + ((BIT_W + 1)'(1) << k);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      bitpos <= '0;
      k      <= K_W'(BIT_W - 1);
    end else if (busy) begin
      if ((m >> trial) != '0) bitpos <= trial[BIT_W-1:0];
      if (k == '0) begin
        busy <= 1'b0;
      end else begin
        k <= k - 1'b1;
      end
    end
  end

  always_comb begin
    shr       = bitpos > TOP_POS;
    amt       = shr ? (bitpos - TOP_POS) : (TOP_POS - bitpos);
    shifted   = shr ? (raw_in >> amt) : (raw_in << amt);
    alpha_out = shifted[ALPHA_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/hmm_forward_state_predictor_top.sv @@
// hmm_forward_state_predictor_top: sequencer, alpha and raw memories, max
// tracking and result register. Uses hmmfp_pkg, hmmfp_tables, hmmfp_mac and
// hmmfp_norm.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+--------------------
//   item     | opcode row_index col_index prob_value      | item_valid/stall
//            | observation first_of_sequence last_of_seq  |
//   result   | predicted_state all_zero                   | result_valid/stall
//   cfg      | num_states                                 | cfg_valid/ready
//
// Load transactions are written into the tables when accepted. An observe
// transaction does every product in turn on the one shared multiplier
// (initial times emission as a first step, transition sums and then emission
// otherwise) and then one pass over alpha. Synchronous reset; alpha reads as
// zero until the first observe completes. item_stall is high in reset and
// while an observe is in progress; a pending result does not block new items,
// only the delivery of the next result.
`default_nettype none

module hmm_forward_state_predictor_top
  import hmmfp_pkg::*;
#(
  parameter int MAX_STATES  = DEF_MAX_STATES,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [ROW_W-1:0]  row_index,
  input  wire logic [COL_W-1:0]  col_index,
  input  wire logic [PROB_W-1:0] prob_value,
  input  wire logic [OBS_W-1:0]  observation,
  input  wire logic              first_of_sequence,
  input  wire logic              last_of_sequence,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic      [PRED_W-1:0] predicted_state,
  output logic                   all_zero,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [NS_W-1:0]   num_states
);

  localparam int SI_W  = $clog2(MAX_STATES);
  localparam int N_W   = $clog2(MAX_STATES + 1);
  localparam int TR_W  = $clog2(MAX_STATES * MAX_STATES);
  localparam int EM_W  = $clog2(MAX_STATES * MAX_SYMBOLS);
  localparam int SUM_W = ALPHA_W + PROB_W - 1 + $clog2(MAX_STATES);
  localparam int A_W   = SUM_W - (PROB_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_MAC, S_GAP, S_EMIT, S_DRAIN, S_SEARCH, S_NORM, S_NWAIT, S_FIN
  } state_t;

  state_t state;

  logic [NS_W-1:0]   state_count;
  logic [N_W-1:0]    n_act, n_last;
  logic [SI_W-1:0]   i_cnt, j_cnt, wj, best, nrm_j;
  logic [OBS_W-1:0]  obs;
  logic              first_q, last_q, obs_ok;
  logic              alpha_valid, nrm_v;
  logic [SUM_W-1:0]  m;

  logic [31:0]       tr_lin, em_lin;
  logic [TR_W-1:0]   trans_raddr;
  logic [EM_W-1:0]   emis_raddr;
  logic [PROB_W-1:0] init_q, trans_q, emis_q;

  logic [ALPHA_W-1:0] alpha_mem [MAX_STATES];
  logic [SUM_W-1:0]   raw_mem   [MAX_STATES];
  logic [ALPHA_W-1:0] alpha_q, norm_alpha;
  logic [SUM_W-1:0]   raw_q;

  mac_tag_t          issue_tag, tag1, tag2;
  logic [A_W-1:0]    op_a;
  logic [PROB_W-1:0] op_b;
  logic [SUM_W-1:0]  prod, acc;

  logic item_acc, load_en, i_last, j_last, drained, norm_start, norm_busy, res_free;

  // active state count
  always_comb begin
    if (state_count == '0) begin
      n_act = N_W'(1);
    end else if (32'(state_count) > 32'(MAX_STATES)) begin
      n_act = N_W'(MAX_STATES);
    end else begin
      n_act = N_W'(state_count);
    end
    n_last = n_act - 1'b1;
  end

  assign item_stall = rst || (state != S_IDLE);
  assign cfg_ready  = !rst && (state == S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign load_en    = item_acc && (opcode_t'(opcode) != OP_OBSERVE);
  assign i_last     = (N_W'(i_cnt) == n_last);
  assign j_last     = (N_W'(j_cnt) == n_last);
  assign obs_ok     = 32'(obs) < 32'(MAX_SYMBOLS);
  assign drained    = !tag1.valid && !tag2.valid;
  assign norm_start = (state == S_DRAIN) && drained;
  assign res_free   = !result_valid || !result_stall;

  always_comb begin
    tr_lin      = 32'(i_cnt) * 32'(MAX_STATES) + 32'(j_cnt);
    em_lin      = 32'(j_cnt) * 32'(MAX_SYMBOLS) + 32'(obs);
    trans_raddr = tr_lin[TR_W-1:0];
    emis_raddr  = em_lin[EM_W-1:0];
  end

  hmmfp_tables #(
    .MAX_STATES (MAX_STATES),
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_tables (
    .clk        (clk),
    .load_en    (load_en),
    .opcode     (opcode),
    .row_index  (row_index),
    .col_index  (col_index),
    .prob_value (prob_value),
    .init_raddr (j_cnt),
    .trans_raddr(trans_raddr),
    .emis_raddr (emis_raddr),
    .init_q     (init_q),
    .trans_q    (trans_q),
    .emis_q     (emis_q)
  );

  // issue side
  always_comb begin
    issue_tag = '0;
    unique case (state)
      S_FIRST: issue_tag = '{valid: 1'b1, is_raw: 1'b1, first_i: 1'b0};
      S_MAC:   issue_tag = '{valid: 1'b1, is_raw: 1'b0, first_i: (i_cnt == '0)};
      S_EMIT:  issue_tag = '{valid: 1'b1, is_raw: 1'b1, first_i: 1'b0};
      default: issue_tag = '0;
    endcase
  end

  // operand select, in the cycle after issue
  always_comb begin
    if (tag1.is_raw) begin
      op_b = obs_ok ? emis_q : '0;
      op_a = first_q ? A_W'(init_q) : acc[SUM_W-1:PROB_W-1];
    end else begin
      op_b = trans_q;
      op_a = alpha_valid ? A_W'(alpha_q) : '0;
    end
  end

  hmmfp_mac #(
    .SUM_W(SUM_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .tag_in (tag1),
    .a      (op_a),
    .b      (op_b),
    .tag_out(tag2),
    .prod   (prod),
    .acc    (acc)
  );

  hmmfp_norm #(
    .SUM_W(SUM_W)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (norm_start),
    .m        (m),
    .raw_in   (raw_q),
    .busy     (norm_busy),
    .alpha_out(norm_alpha)
  );

  // memories and raw collection
  always_ff @(posedge clk) begin
    alpha_q <= alpha_mem[i_cnt];
    raw_q   <= raw_mem[j_cnt];
    if (nrm_v) begin
      alpha_mem[nrm_j] <= ((N_W'(nrm_j) < n_act) && (m != '0)) ? norm_alpha : '0;
    end
    if (tag2.valid && tag2.is_raw) begin
      raw_mem[wj] <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1  <= '0;
      nrm_v <= 1'b0;
    end else begin
      tag1  <= issue_tag;
      nrm_v <= (state == S_NORM);
    end
    nrm_j <= j_cnt;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      state_count  <= NS_RESET_VAL;
      alpha_valid  <= 1'b0;
      result_valid <= 1'b0;
      i_cnt        <= '0;
      j_cnt        <= '0;
      wj           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) state_count <= num_states;
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (tag2.valid && tag2.is_raw) begin
        wj <= wj + 1'b1;
        if (prod > m) begin
          m    <= prod;
          best <= wj;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc && (opcode_t'(opcode) == OP_OBSERVE)) begin
            obs     <= observation;
            first_q <= first_of_sequence;
            last_q  <= last_of_sequence;
            i_cnt   <= '0;
            j_cnt   <= '0;
            wj      <= '0;
            m       <= '0;
            best    <= '0;
            state   <= first_of_sequence ? S_FIRST : S_MAC;
          end
        end
        S_FIRST: begin
          if (j_last) begin
            state <= S_DRAIN;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_MAC: begin
          if (i_last) begin
            i_cnt <= '0;
            state <= S_GAP;
          end else begin
            i_cnt <= i_cnt + 1'b1;
          end
        end
        S_GAP: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (j_last) begin
            state <= S_DRAIN;
          end else begin
            j_cnt <= j_cnt + 1'b1;
            state <= S_MAC;
          end
        end
        S_DRAIN: begin
          if (drained) begin
            j_cnt <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (!norm_busy) state <= S_NORM;
        end
        S_NORM: begin
          if (j_cnt == SI_W'(MAX_STATES - 1)) begin
            state <= S_NWAIT;
          end else begin
            j_cnt <= j_cnt + 1'b1;
          end
        end
        S_NWAIT: begin
          alpha_valid <= 1'b1;
          state       <= S_FIN;
        end
        S_FIN: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (res_free) begin
            result_valid    <= 1'b1;
            predicted_state <= PRED_W'(best);
            all_zero        <= (m == '0);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
